// ===== design/lapef_pkg.sv =====
// shared types, constants and helpers for the laplacian edge filter
`timescale 1ns / 1ps
package lapef_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned SizeW        = 11;
  localparam int unsigned SizeReset    = 1024;
  localparam int unsigned SizeMin      = 2;
  localparam int unsigned ChanW        = 8;
  localparam int unsigned ApbAddrW     = 4;
  localparam int unsigned ApbDataW     = 32;

  typedef enum logic [1:0] {
    RegImageWidth    = 2'd0,
    RegImageHeight   = 2'd1,
    RegEdgeThreshold = 2'd2
  } reg_idx_e;

  typedef logic [ChanW-1:0] chan_t;

  typedef struct packed {
    logic  drain;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
    chan_t alpha_in;
  } lapef_in_t;

  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    chan_t alpha_out;
    logic  frame_end;
  } lapef_out_t;

  // red in the low byte, alpha in the high byte
  typedef struct packed {
    chan_t alpha;
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // border mirroring choices for one window, plus the end-of-frame mark
  typedef struct packed {
    logic top_refl;
    logic bot_refl;
    logic left_refl;
    logic right_refl;
    logic frame_end;
  } tap_sel_t;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned max_v);
    int unsigned r;
    r = v;
    if (r < SizeMin) r = SizeMin;
    if (r > max_v) r = max_v;
    return r;
  endfunction

endpackage

// ===== design/lapef_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module lapef_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/laplacian_edge_filter_core.sv =====
// laplacian edge filter core: streaming 3x3 laplacian on rgba pixels, mirrored borders
// throughput: one request per cycle unless the output stalls, bounded by the single write and
// read port of each line store; a result passes stage a, the window, the sums and the output
// register after the request that completes its window (the pixel image_width+1 places after the
// centre, or a drain at the end of the frame); reset clears configuration, position, drain and
// pipeline valid state; the line stores and the window are not cleared and need no clearing pass
`timescale 1ns / 1ps
module laplacian_edge_filter_core #(
  parameter int unsigned MAX_WIDTH  = lapef_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = lapef_pkg::MaxHeightDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lapef_pkg::lapef_in_t                in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lapef_pkg::lapef_out_t               out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lapef_pkg::ApbAddrW-1:0]      paddr,
  input  logic [lapef_pkg::ApbDataW-1:0]      pwdata,
  output logic [lapef_pkg::ApbDataW-1:0]      prdata,
  output logic                                pready
);

  import lapef_pkg::*;

  localparam int unsigned ColW     = $clog2(MAX_WIDTH);
  localparam int unsigned RowW     = $clog2(MAX_HEIGHT);
  localparam int unsigned EffWW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EffHW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned NSumW    = ChanW + 3;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned NumTaps  = 8;
  localparam logic [EffWW-1:0] EffWidthRst  = EffWW'(clamp_size(SizeReset, MAX_WIDTH));
  localparam logic [EffHW-1:0] EffHeightRst = EffHW'(clamp_size(SizeReset, MAX_HEIGHT));
  // window columns oldest to newest, rows top to bottom
  localparam logic [1:0] TapLo  = 2'd0;
  localparam logic [1:0] TapMid = 2'd1;
  localparam logic [1:0] TapHi  = 2'd2;

  // configuration
  logic               cfg_we;
  reg_idx_e           cfg_idx;
  logic               size_wr;
  logic [SizeW-1:0]   image_width_q;
  logic [SizeW-1:0]   image_height_q;
  chan_t              edge_threshold_q;
  logic [EffWW-1:0]   eff_w_q;
  logic [EffHW-1:0]   eff_h_q;

  // positions
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  logic               drain_act_q, drain_act_d;
  logic [EffWW-1:0]   drain_col_q, drain_col_d;
  logic [EffWW-1:0]   col_next;
  logic [EffHW-1:0]   row_next;
  logic [EffWW-1:0]   drain_col_next;

  // request decode
  logic               in_acc;
  logic               entry_new;
  logic               entry_emit;
  logic               entry_write;
  tap_sel_t           entry_sel;
  logic [ColW-1:0]    rd_addr;
  pixel_t             in_pix;

  // pipeline handshake
  logic a_valid_q, a_valid_d, a_free, a_move;
  logic b_valid_q, b_valid_d, b_free, b_move;
  logic c_valid_q, c_valid_d, c_free, c_move;
  logic d_valid_q, d_valid_d, d_free;

  // stage a: line store read in flight
  logic               a_emit_q;
  logic               a_write_q;
  logic [ColW-1:0]    a_col_q;
  pixel_t             a_pix_q;
  tap_sel_t           a_sel_q;
  pixel_t             upper_rd;
  pixel_t             middle_rd;

  // stage b: window
  pixel_t             win_q [3][3];
  tap_sel_t           b_sel_q;
  logic [1:0]         r_top, r_bot, c_left, c_right;
  pixel_t             taps [NumTaps];
  logic [NSumW-1:0]   nsum_d [NumChan];

  // stage c: neighbour sums
  logic [NSumW-1:0]   c_nsum_q [NumChan];
  pixel_t             c_centre_q;
  logic               c_frame_end_q;
  logic [NSumW-1:0]   c8 [NumChan];
  logic [NSumW-1:0]   diff [NumChan];
  chan_t              res [NumChan];

  // stage d: output register
  lapef_out_t         d_data_q;
  lapef_out_t         d_data_d;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign size_wr = cfg_we && (cfg_idx == RegImageWidth || cfg_idx == RegImageHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q    <= SizeW'(SizeReset);
      image_height_q   <= SizeW'(SizeReset);
      edge_threshold_q <= '0;
      eff_w_q          <= EffWidthRst;
      eff_h_q          <= EffHeightRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegImageWidth: begin
          image_width_q <= pwdata[SizeW-1:0];
          eff_w_q       <= EffWW'(clamp_size(32'(pwdata[SizeW-1:0]), MAX_WIDTH));
        end
        RegImageHeight: begin
          image_height_q <= pwdata[SizeW-1:0];
          eff_h_q        <= EffHW'(clamp_size(32'(pwdata[SizeW-1:0]), MAX_HEIGHT));
        end
        RegEdgeThreshold: begin
          edge_threshold_q <= pwdata[ChanW-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegImageWidth:    prdata = ApbDataW'(image_width_q);
      RegImageHeight:   prdata = ApbDataW'(image_height_q);
      RegEdgeThreshold: prdata = ApbDataW'(edge_threshold_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign d_free = !d_valid_q || out_ready_i;
  assign c_move = c_valid_q && d_free;
  assign c_free = !c_valid_q || d_free;
  assign b_move = b_valid_q && c_free;
  assign b_free = !b_valid_q || c_free;
  assign a_move = a_valid_q && b_free;
  assign a_free = !a_valid_q || b_free;

  assign in_ready_o = a_free;
  assign in_acc     = in_valid_i && a_free;

  assign a_valid_d = a_free ? (in_acc && entry_new) : 1'b1;
  assign b_valid_d = b_free ? (a_move && a_emit_q) : 1'b1;
  assign c_valid_d = c_free ? b_move : 1'b1;
  assign d_valid_d = d_free ? c_move : 1'b1;

  // ---------------------------------------------------------------- positions
  assign col_next       = EffWW'(col_q) + EffWW'(1);
  assign row_next       = EffHW'(row_q) + EffHW'(1);
  assign drain_col_next = drain_col_q + EffWW'(1);

  assign in_pix = '{alpha: in_data_i.alpha_in, blue: in_data_i.blue_in,
                    green: in_data_i.green_in, red: in_data_i.red_in};

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    drain_act_d = drain_act_q;
    drain_col_d = drain_col_q;
    entry_new   = 1'b0;
    entry_emit  = 1'b0;
    entry_write = 1'b0;
    entry_sel   = '0;
    rd_addr     = col_q;
    if (!in_data_i.drain) begin
      entry_new   = 1'b1;
      entry_write = 1'b1;
      entry_emit  = (row_q > RowW'(1)) || ((row_q == RowW'(1)) && (col_q != '0));
      if (col_q == '0) begin
        // window centres on the last column of the row two up
        entry_sel.top_refl   = (row_q == RowW'(2));
        entry_sel.right_refl = 1'b1;
      end else begin
        entry_sel.top_refl  = (row_q == RowW'(1));
        entry_sel.left_refl = (col_q == ColW'(1));
      end
      if (in_acc) begin
        drain_act_d = 1'b0;
        if (col_next == eff_w_q) begin
          col_d = '0;
          if (row_next == eff_h_q) begin
            row_d       = '0;
            drain_act_d = 1'b1;
            drain_col_d = '0;
          end else begin
            row_d = row_next[RowW-1:0];
          end
        end else begin
          col_d = col_next[ColW-1:0];
        end
      end
    end else if (drain_act_q) begin
      // drains walk a virtual row below the frame
      entry_new  = 1'b1;
      entry_emit = 1'b1;
      rd_addr    = drain_col_q[ColW-1:0];
      if (drain_col_q == '0) begin
        entry_sel.top_refl   = (eff_h_q == EffHW'(2));
        entry_sel.right_refl = 1'b1;
      end else begin
        entry_sel.bot_refl   = 1'b1;
        entry_sel.left_refl  = (drain_col_q == EffWW'(1));
        entry_sel.right_refl = (drain_col_q == eff_w_q);
      end
      entry_sel.frame_end = (drain_col_q == eff_w_q);
      if (in_acc) begin
        if (drain_col_q == eff_w_q) begin
          drain_act_d = 1'b0;
        end else begin
          drain_col_d = drain_col_next;
        end
      end
    end
    if (size_wr) begin
      col_d       = '0;
      row_d       = '0;
      drain_act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      drain_act_q <= 1'b0;
      drain_col_q <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      drain_act_q <= drain_act_d;
      drain_col_q <= drain_col_d;
      a_valid_q   <= a_valid_d;
      b_valid_q   <= b_valid_d;
      c_valid_q   <= c_valid_d;
      d_valid_q   <= d_valid_d;
    end
  end

  // ---------------------------------------------------------------- line stores
  // middle holds the previous row, upper the row before it
  lapef_ram #(
    .WIDTH($bits(pixel_t)),
    .DEPTH(MAX_WIDTH)
  ) u_upper_line (
    .clk_i  (clk_i),
    .we_i   (a_move && a_write_q),
    .waddr_i(a_col_q),
    .wdata_i(middle_rd),
    .re_i   (in_acc && entry_new),
    .raddr_i(rd_addr),
    .rdata_o(upper_rd)
  );

  lapef_ram #(
    .WIDTH($bits(pixel_t)),
    .DEPTH(MAX_WIDTH)
  ) u_middle_line (
    .clk_i  (clk_i),
    .we_i   (a_move && a_write_q),
    .waddr_i(a_col_q),
    .wdata_i(a_pix_q),
    .re_i   (in_acc && entry_new),
    .raddr_i(rd_addr),
    .rdata_o(middle_rd)
  );

  // ---------------------------------------------------------------- stage a
  always_ff @(posedge clk_i) begin
    if (in_acc && entry_new) begin
      a_emit_q  <= entry_emit;
      a_write_q <= entry_write;
      a_col_q   <= col_q;
      a_pix_q   <= in_pix;
      a_sel_q   <= entry_sel;
    end
  end

  // ---------------------------------------------------------------- stage b
  always_ff @(posedge clk_i) begin
    if (a_move) begin
      win_q[TapLo]         <= win_q[TapMid];
      win_q[TapMid]        <= win_q[TapHi];
      win_q[TapHi][TapLo]  <= upper_rd;
      win_q[TapHi][TapMid] <= middle_rd;
      win_q[TapHi][TapHi]  <= a_pix_q;
      b_sel_q              <= a_sel_q;
    end
  end

  always_comb begin
    r_top   = b_sel_q.top_refl   ? TapHi : TapLo;
    r_bot   = b_sel_q.bot_refl   ? TapLo : TapHi;
    c_left  = b_sel_q.left_refl  ? TapHi : TapLo;
    c_right = b_sel_q.right_refl ? TapLo : TapHi;
    taps[0] = win_q[c_left][r_top];
    taps[1] = win_q[TapMid][r_top];
    taps[2] = win_q[c_right][r_top];
    taps[3] = win_q[c_left][TapMid];
    taps[4] = win_q[c_right][TapMid];
    taps[5] = win_q[c_left][r_bot];
    taps[6] = win_q[TapMid][r_bot];
    taps[7] = win_q[c_right][r_bot];
    for (int ch = 0; ch < NumChan; ch++) begin
      nsum_d[ch] = '0;
      for (int i = 0; i < NumTaps; i++) begin
        nsum_d[ch] = nsum_d[ch] + NSumW'(taps[i][ChanW*ch +: ChanW]);
      end
    end
  end

  // ---------------------------------------------------------------- stage c
  always_ff @(posedge clk_i) begin
    if (b_move) begin
      c_nsum_q      <= nsum_d;
      c_centre_q    <= win_q[TapMid][TapMid];
      c_frame_end_q <= b_sel_q.frame_end;
    end
  end

  // 8 x centre minus neighbours, clamped to a byte, then thresholded
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      c8[ch] = {c_centre_q[ChanW*ch +: ChanW], 3'b000};
      if (c8[ch] > c_nsum_q[ch]) begin
        diff[ch] = c8[ch] - c_nsum_q[ch];
      end else begin
        diff[ch] = '0;
      end
      if (|diff[ch][NSumW-1:ChanW]) begin
        res[ch] = '1;
      end else begin
        res[ch] = diff[ch][ChanW-1:0];
      end
      if (res[ch] <= edge_threshold_q) begin
        res[ch] = '0;
      end
    end
    d_data_d.red_out   = res[0];
    d_data_d.green_out = res[1];
    d_data_d.blue_out  = res[2];
    d_data_d.alpha_out = c_centre_q.alpha;
    d_data_d.frame_end = c_frame_end_q;
  end

  // ---------------------------------------------------------------- stage d
  always_ff @(posedge clk_i) begin
    if (c_move) begin
      d_data_q <= d_data_d;
    end
  end

  assign out_valid_o = d_valid_q;
  assign out_data_o  = d_data_q;

endmodule

// ===== tb/laplacian_edge_filter_core_tb.sv =====
// self-checking testbench for the laplacian edge filter core
`timescale 1ns / 1ps
module laplacian_edge_filter_core_tb;
  import lapef_pkg::*;

  localparam int unsigned LineMax     = MaxWidthDef;
  localparam int unsigned RowsMax     = MaxHeightDef;
  localparam int unsigned UnusedReg   = 3;
  localparam int unsigned SettleCyc   = 8;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned RandomItems = 420;
  localparam int unsigned EdgeItems   = 60;

  typedef enum logic [1:0] {ExpNone, ExpGiven, ExpModel} row_chk_e;
  typedef enum logic {RowWrite, RowItem} row_kind_e;
  typedef enum int unsigned {TexNoise, TexSmooth, TexSparse} texture_e;

  typedef struct {
    row_kind_e   kind;
    int unsigned reg_sel;
    logic [31:0] reg_val;
    lapef_in_t   item;
    row_chk_e    chk;
    lapef_out_t  result;
  } stim_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  lapef_in_t           in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  lapef_out_t          out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  always #5 clk_i = ~clk_i;

  laplacian_edge_filter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predictor state
  pixel_t           line_ring [3][LineMax];
  logic [SizeW-1:0] width_reg  = SizeW'(SizeReset);
  logic [SizeW-1:0] height_reg = SizeW'(SizeReset);
  logic [7:0]       thresh_reg = '0;
  int unsigned      col_pos    = 0;
  int unsigned      row_pos    = 0;
  int unsigned      flush_left = 0;

  lapef_out_t  edge_results_q [$];
  stim_row_t   script [$];
  int unsigned fail_count  = 0;
  bit          quiet_phase = 1'b0;

  function automatic int unsigned clamp_dim(logic [SizeW-1:0] v, int unsigned top);
    if (v < SizeMin) return SizeMin;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int mirror(int p, int n);
    if (p < 0) return -p;
    if (p > n - 1) return 2 * n - 2 - p;
    return p;
  endfunction

  // 3x3 window around (y, x); the tap at (nr, nc) is the pixel not yet stored
  function automatic lapef_out_t window_result(int y, int x, pixel_t fresh, int nr, int nc,
                                               logic last);
    int         w, h, ry, rx, v, dy, dx, c;
    int         sum [3];
    chan_t      ch [3];
    pixel_t     p, centre;
    lapef_out_t r;
    w = clamp_dim(width_reg, LineMax);
    h = clamp_dim(height_reg, RowsMax);
    sum = '{0, 0, 0};
    centre = '0;
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        ry = mirror(y + dy, h);
        rx = mirror(x + dx, w);
        p = (ry == nr && rx == nc) ? fresh : line_ring[ry % 3][rx];
        ch[0] = p.red;
        ch[1] = p.green;
        ch[2] = p.blue;
        for (c = 0; c < 3; c++) begin
          if (dy == 0 && dx == 0) sum[c] += 8 * int'(ch[c]);
          else sum[c] -= int'(ch[c]);
        end
        if (dy == 0 && dx == 0) centre = p;
      end
    end
    for (c = 0; c < 3; c++) begin
      v = sum[c];
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      if (v <= int'(thresh_reg)) v = 0;
      ch[c] = chan_t'(v);
    end
    r.red_out   = ch[0];
    r.green_out = ch[1];
    r.blue_out  = ch[2];
    r.alpha_out = centre.alpha;
    r.frame_end = last;
    return r;
  endfunction

  function automatic bit laplacian_step(lapef_in_t it, output lapef_out_t res);
    int unsigned w, h, total, k, c, idx;
    pixel_t      px;
    bit          made;
    w = clamp_dim(width_reg, LineMax);
    h = clamp_dim(height_reg, RowsMax);
    total = w * h;
    made = 1'b0;
    res = '0;
    if (it.drain) begin
      if (flush_left == 0) return 1'b0;
      if (flush_left > total) flush_left = total;
      idx = total - flush_left;
      res = window_result(idx / w, idx % w, '0, -1, -1, idx == total - 1);
      flush_left--;
      return 1'b1;
    end
    px = '{alpha: it.alpha_in, blue: it.blue_in, green: it.green_in, red: it.red_in};
    // a real pixel abandons any flush still owed
    flush_left = 0;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    k = row_pos * w + col_pos;
    if (k >= w + 1) begin
      c = k - w - 1;
      res = window_result(c / w, c % w, px, row_pos, col_pos, 1'b0);
      made = 1'b1;
    end
    line_ring[row_pos % 3][col_pos] = px;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        flush_left = w + 1;
      end
    end
    return made;
  endfunction

  function automatic void apply_register(int unsigned sel, logic [31:0] v);
    if (sel == RegEdgeThreshold) begin
      thresh_reg = v[7:0];
    end else if (sel == RegImageWidth || sel == RegImageHeight) begin
      if (sel == RegImageWidth) width_reg = v[SizeW-1:0];
      else height_reg = v[SizeW-1:0];
      col_pos = 0;
      row_pos = 0;
      flush_left = 0;
    end
  endfunction

  function automatic logic [ApbDataW-1:0] reg_readback(int unsigned sel);
    if (sel == RegImageWidth) return ApbDataW'(width_reg);
    if (sel == RegImageHeight) return ApbDataW'(height_reg);
    return ApbDataW'(thresh_reg);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic lapef_in_t pix(chan_t r, chan_t g, chan_t b, chan_t a);
    return {1'b0, r, g, b, a};
  endfunction

  // drain items carry junk in the pixel fields, which must be ignored
  function automatic lapef_in_t drain_item();
    return {1'b1, 32'($urandom)};
  endfunction

  function automatic lapef_out_t res_of(chan_t r, chan_t g, chan_t b, chan_t a, logic fe);
    return {r, g, b, a, fe};
  endfunction

  function automatic lapef_in_t make_pixel(texture_e tex, pixel_t base);
    lapef_in_t   it;
    logic [31:0] noise;
    noise = $urandom;
    it.drain = 1'b0;
    it.alpha_in = noise[31:24];
    it.red_in   = noise[7:0];
    it.green_in = noise[15:8];
    it.blue_in  = noise[23:16];
    if (tex == TexSmooth) begin
      it.red_in   = base.red + chan_t'(noise[3:0]);
      it.green_in = base.green + chan_t'(noise[11:8]);
      it.blue_in  = base.blue + chan_t'(noise[19:16]);
    end else if (tex == TexSparse && $urandom_range(0, 7) != 0) begin
      it.red_in   = base.red;
      it.green_in = base.green;
      it.blue_in  = base.blue;
    end
    return it;
  endfunction

  function automatic void add_write(int unsigned sel, logic [31:0] val);
    stim_row_t row;
    row = '{kind: RowWrite, reg_sel: sel, reg_val: val, item: '0, chk: ExpNone, result: '0};
    script.push_back(row);
  endfunction

  function automatic void add_item(lapef_in_t it, row_chk_e chk, lapef_out_t res);
    stim_row_t row;
    row = '{kind: RowItem, reg_sel: 0, reg_val: '0, item: it, chk: chk, result: res};
    script.push_back(row);
  endfunction

  task automatic check_result(lapef_out_t want, lapef_out_t got);
    if (got.red_out !== want.red_out) begin
      $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
      fail_count++;
    end
    if (got.green_out !== want.green_out) begin
      $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
      fail_count++;
    end
    if (got.blue_out !== want.blue_out) begin
      $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
      fail_count++;
    end
    if (got.alpha_out !== want.alpha_out) begin
      $error("alpha_out: expected %0d, got %0d", want.alpha_out, got.alpha_out);
      fail_count++;
    end
    if (got.frame_end !== want.frame_end) begin
      $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
      fail_count++;
    end
  endtask

  task automatic apb_access(int unsigned sel, logic [31:0] val, bit is_write);
    logic [ApbDataW-1:0] want;
    want = reg_readback(sel);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ApbAddrW'(sel * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (is_write) begin
      apply_register(sel, val);
    end else if (prdata !== want) begin
      $error("register %0d readback: expected %0h, got %0h", sel, want, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(int unsigned sel, logic [31:0] val);
    apb_access(sel, val, 1'b1);
    if (sel <= RegEdgeThreshold) apb_access(sel, '0, 1'b0);
  endtask

  // drop valid, wait for every owed result, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (edge_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic push_request(input lapef_in_t it, input int unsigned gap, input bit hold,
                              input row_chk_e chk, input lapef_out_t given, output bit made);
    lapef_out_t res;
    if (gap > 0 || hold) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      if (hold) while (edge_results_q.size() != 0) @(posedge clk_i);
      repeat (gap > 0 ? gap - 1 : 0) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    made = laplacian_step(it, res);
    if (chk == ExpModel && made) edge_results_q.push_back(res);
    else if (chk == ExpGiven) edge_results_q.push_back(given);
  endtask

  initial begin : sink_stall
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= 1'b1;
        hold_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (edge_results_q.size() == 0) begin
        $error("result with none expected: %p", out_data_o);
        fail_count++;
      end else begin
        check_result(edge_results_q.pop_front(), out_data_o);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   row;
    lapef_out_t  none_out;
    pixel_t      base;
    texture_e    tex;
    bit          made, hold, paused;
    int unsigned counted, w, h, npix, ndrain, cut, r, wv, hv, tv, f, i, nframes;
    none_out = '0;
    paused = 1'b0;
    counted = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_access(RegImageWidth, '0, 1'b0);
    apb_access(RegImageHeight, '0, 1'b0);
    apb_access(RegEdgeThreshold, '0, 1'b0);

    // nothing owed after reset, and early pixels of a frame give nothing
    add_item(drain_item(), ExpNone, none_out);
    add_item(pix(8'h00, 8'h00, 8'h00, 8'h00), ExpNone, none_out);
    add_item(pix(8'hff, 8'hff, 8'hff, 8'hff), ExpNone, none_out);
    add_write(RegImageWidth, 2);
    add_write(RegImageHeight, 2);
    // flat 2x2 frame: every sum is zero
    add_item(pix(8'hff, 8'hff, 8'hff, 8'ha5), ExpNone, none_out);
    add_item(pix(8'hff, 8'hff, 8'hff, 8'ha5), ExpNone, none_out);
    add_item(pix(8'hff, 8'hff, 8'hff, 8'ha5), ExpNone, none_out);
    add_item(pix(8'hff, 8'hff, 8'hff, 8'ha5), ExpGiven, res_of(0, 0, 0, 8'ha5, 1'b0));
    add_item(drain_item(), ExpGiven, res_of(0, 0, 0, 8'ha5, 1'b0));
    add_item(drain_item(), ExpGiven, res_of(0, 0, 0, 8'ha5, 1'b0));
    add_item(drain_item(), ExpGiven, res_of(0, 0, 0, 8'ha5, 1'b1));
    add_item(drain_item(), ExpNone, none_out);
    // lone bright pixel saturates its own sum
    add_item(pix(8'hff, 8'hff, 8'hff, 8'h00), ExpNone, none_out);
    add_item(pix(8'h00, 8'h00, 8'h00, 8'h3c), ExpNone, none_out);
    add_item(pix(8'h00, 8'h00, 8'h00, 8'h3c), ExpNone, none_out);
    add_item(pix(8'h00, 8'h00, 8'h00, 8'h3c), ExpGiven, res_of(8'hff, 8'hff, 8'hff, 0, 1'b0));
    add_item(drain_item(), ExpModel, none_out);
    add_item(drain_item(), ExpModel, none_out);
    add_item(drain_item(), ExpModel, none_out);
    // top threshold kills every channel; the unused address must change nothing
    add_write(RegEdgeThreshold, 255);
    add_write(UnusedReg, 32'hffff_ffff);
    add_item(pix(8'h12, 8'h34, 8'h56, 8'h78), ExpNone, none_out);
    add_item(pix(8'h9a, 8'hbc, 8'hde, 8'hf0), ExpNone, none_out);
    add_item(pix(8'hff, 8'h00, 8'hff, 8'h00), ExpNone, none_out);
    add_item(pix(8'h00, 8'hff, 8'h00, 8'hff), ExpGiven, res_of(0, 0, 0, 8'h78, 1'b0));
    add_item(drain_item(), ExpGiven, res_of(0, 0, 0, 8'hf0, 1'b0));
    // pixel while flush is owed starts a new frame; then a drain mid-frame
    add_item(pix(8'h80, 8'h7f, 8'h01, 8'hfe), ExpNone, none_out);
    add_item(drain_item(), ExpNone, none_out);

    foreach (script[k]) begin
      row = script[k];
      if (row.kind == RowWrite) begin
        settle();
        write_reg(row.reg_sel, row.reg_val);
      end else begin
        push_request(row.item, pick_gap(), 1'b0, row.chk, row.result, made);
      end
    end

    while (counted < RandomItems) begin
      settle();
      quiet_phase = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) wv = $urandom_range(2, 8);
      else if (r < 8) wv = $urandom_range(9, 40);
      else wv = $urandom_range(0, 1);
      r = $urandom_range(0, 9);
      if (r < 7 || wv > 8) hv = $urandom_range(2, (wv > 8) ? 4 : 6);
      else if (r < 8) hv = $urandom_range(0, 1);
      else hv = $urandom_range(7, 16);
      r = $urandom_range(0, 9);
      if (r < 3) tv = 0;
      else if (r == 3) tv = 255;
      else tv = $urandom_range(1, 254);
      write_reg(RegImageWidth, wv);
      write_reg(RegImageHeight, hv);
      write_reg(RegEdgeThreshold, tv);
      w = clamp_dim(width_reg, LineMax);
      h = clamp_dim(height_reg, RowsMax);
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        tex = texture_e'($urandom_range(0, 2));
        base = $urandom;
        npix = w * h;
        cut = $urandom_range(0, 9);
        // mostly whole frames; sometimes cut short, flush cut short, or extra drains
        if (cut == 0) npix = $urandom_range(1, w * h - 1);
        for (i = 0; i < npix; i++) begin
          hold = ($urandom_range(0, 99) == 0) || (!paused && counted >= 100);
          if (hold) paused = 1'b1;
          push_request(make_pixel(tex, base), pick_gap(), 1'b0 | hold, ExpModel, none_out,
                       made);
          counted++;
        end
        ndrain = w + 1;
        if (cut == 1) ndrain = $urandom_range(0, w);
        else if (cut == 2) ndrain = w + 1 + $urandom_range(1, 3);
        for (i = 0; i < ndrain; i++) begin
          push_request(drain_item(), pick_gap(), 1'b0, ExpModel, none_out, made);
          if (made) counted++;
        end
      end
    end

    // widest line through an out of range width, then tallest frame through an out of
    // range height; both frames are cut short and the drains after them are ignored
    quiet_phase = 1'b0;
    for (f = 0; f < 2; f++) begin
      settle();
      if (f == 0) begin
        write_reg(RegImageWidth, 2047);
        write_reg(RegImageHeight, 0);
      end else begin
        write_reg(RegImageWidth, 2);
        write_reg(RegImageHeight, 2047);
      end
      write_reg(RegEdgeThreshold, $urandom_range(0, 40));
      tex = texture_e'($urandom_range(0, 2));
      base = $urandom;
      for (i = 0; i < EdgeItems; i++)
        push_request(make_pixel(tex, base), pick_gap(), 1'b0, ExpModel, none_out, made);
      for (i = 0; i < 3; i++)
        push_request(drain_item(), pick_gap(), 1'b0, ExpModel, none_out, made);
    end

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
